// ----- sv/lcs_pkg.sv -----
package lcs_pkg;

    localparam int FIELD_BITS = 64;
    localparam int WORD_BITS = 64;
    localparam int CNT_BITS = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] value;
        logic [FIELD_BITS-1:0] modulus;
        logic [FIELD_BITS-1:0] rhs;
    } lcs_req_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] solution;
        logic                  no_solution;
    } lcs_rsp_t;

endpackage

// ----- sv/linear_congruence_solver_core.sv -----
// Linear congruence solver: for each request transaction (value a, modulus m,
// right-hand side c) one response transaction returns x in [0, m) with
// a*x == c (mod m), or no_solution with x = 0 when m < 2 or gcd(a, m) != 1.
// Both channels use valid/ready; req_ready is high only while the core is idle.
// All arithmetic runs on one shared adder and one shared subtractor under a
// sequencer. Restoring division reduces a and c modulo m, each Euclid step
// divides with the same restoring divider and forms the next Bezout coefficient
// by shift-and-add over the quotient bits, and the final modular product
// doubles modulo m for every bit of c, MSB first, and adds the inverse for
// each set bit. An m below 2 goes straight to the result. One request is in
// flight.
// The response sits in an output register; while the receiver stalls, a new
// request may still be taken and computed, and its result waits in the core
// until the output register frees up. Reset returns the sequencer to idle and
// drops rsp_valid.
module linear_congruence_solver_core
    import lcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  lcs_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output lcs_rsp_t rsp_data
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RED_A   = 4'd1;
    localparam logic [3:0] S_RED_C   = 4'd2;
    localparam logic [3:0] S_EUC_CHK = 4'd3;
    localparam logic [3:0] S_EUC_DIV = 4'd4;
    localparam logic [3:0] S_EUC_MUL = 4'd5;
    localparam logic [3:0] S_FIX     = 4'd6;
    localparam logic [3:0] S_MM_DBL  = 4'd7;
    localparam logic [3:0] S_MM_ADD  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    logic [3:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    word_t               m_reg, m_next;
    word_t               c_reg, c_next;
    word_t               r0_reg, r0_next;
    word_t               r1_reg, r1_next;
    word_t               t0_reg, t0_next;
    word_t               t1_reg, t1_next;
    logic                neg0_reg, neg0_next;
    logic                neg1_reg, neg1_next;
    word_t               rem_reg, rem_next;
    word_t               quo_reg, quo_next;
    word_t               d_reg, d_next;
    word_t               mq_reg, mq_next;
    word_t               mt_reg, mt_next;
    word_t               acc_reg, acc_next;
    logic                none_reg, none_next;
    logic                rsp_valid_reg, rsp_valid_next;
    lcs_rsp_t            rsp_data_reg, rsp_data_next;

    logic [WORD_BITS:0]   add_x, add_y, add_sum;
    logic [WORD_BITS:0]   sub_x, sub_y;
    logic [WORD_BITS+1:0] sub_diff;
    logic                 sub_ge;
    logic [WORD_BITS:0]   div_shift;
    word_t                div_rem_step;
    word_t                div_quo_step;
    word_t                addmod_res;
    word_t                req_value, req_modulus, req_rhs;
    word_t                inv_mag;

    assign req_value   = req_data.value[WORD_BITS-1:0];
    assign req_modulus = req_data.modulus[WORD_BITS-1:0];
    assign req_rhs     = req_data.rhs[WORD_BITS-1:0];

    assign div_shift = {rem_reg, quo_reg[WORD_BITS-1]};

    always_comb
    begin
        add_x = {1'b0, acc_reg};
        add_y = {1'b0, mt_reg};
        if (state_reg == S_MM_DBL)
        begin
            add_y = {1'b0, acc_reg};
        end
        add_sum = add_x + add_y;

        sub_x = add_sum;
        sub_y = {1'b0, m_reg};
        if (state_reg inside {S_RED_A, S_RED_C, S_EUC_DIV})
        begin
            sub_x = div_shift;
            sub_y = {1'b0, d_reg};
        end
        else if (state_reg == S_FIX)
        begin
            sub_x = {1'b0, m_reg};
            sub_y = {1'b0, inv_mag};
        end
        sub_diff = {1'b0, sub_x} - {1'b0, sub_y};
        sub_ge   = !sub_diff[WORD_BITS+1];
    end

    assign div_rem_step = sub_ge ? sub_diff[WORD_BITS-1:0] : div_shift[WORD_BITS-1:0];
    assign div_quo_step = {quo_reg[WORD_BITS-2:0], sub_ge};
    assign addmod_res   = sub_ge ? sub_diff[WORD_BITS-1:0] : add_sum[WORD_BITS-1:0];
    assign inv_mag      = (t0_reg == m_reg) ? '0 : t0_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        m_next         = m_reg;
        c_next         = c_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        neg0_next      = neg0_reg;
        neg1_next      = neg1_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        d_next         = d_reg;
        mq_next        = mq_reg;
        mt_next        = mt_reg;
        acc_next       = acc_reg;
        none_next      = none_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    m_next   = req_modulus;
                    c_next   = req_rhs;
                    d_next   = req_modulus;
                    quo_next = req_value;
                    rem_next = '0;
                    cnt_next = '0;
                    if (req_modulus < WORD_BITS'(2))
                    begin
                        acc_next   = '0;
                        none_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RED_A;
                    end
                end
            end
            S_RED_A, S_RED_C:
            begin
                rem_next = div_rem_step;
                quo_next = div_quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next = '0;
                    if (state_reg == S_RED_A)
                    begin
                        r0_next    = m_reg;
                        r1_next    = div_rem_step;
                        quo_next   = c_reg;
                        rem_next   = '0;
                        state_next = S_RED_C;
                    end
                    else
                    begin
                        c_next     = div_rem_step;
                        t0_next    = '0;
                        t1_next    = WORD_BITS'(1);
                        neg0_next  = 1'b0;
                        neg1_next  = 1'b0;
                        state_next = S_EUC_CHK;
                    end
                end
            end
            S_EUC_CHK:
            begin
                if (r1_reg == '0)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    quo_next   = r0_reg;
                    d_next     = r1_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_EUC_DIV;
                end
            end
            S_EUC_DIV:
            begin
                rem_next = div_rem_step;
                quo_next = div_quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    r0_next    = r1_reg;
                    r1_next    = div_rem_step;
                    mq_next    = div_quo_step;
                    mt_next    = t1_reg;
                    acc_next   = t0_reg;
                    state_next = S_EUC_MUL;
                end
            end
            S_EUC_MUL:
            begin
                if (mq_reg == '0)
                begin
                    t0_next    = t1_reg;
                    t1_next    = acc_reg;
                    neg0_next  = neg1_reg;
                    neg1_next  = !neg1_reg;
                    state_next = S_EUC_CHK;
                end
                else
                begin
                    if (mq_reg[0])
                    begin
                        acc_next = add_sum[WORD_BITS-1:0];
                    end
                    mq_next = mq_reg >> 1;
                    mt_next = mt_reg << 1;
                end
            end
            S_FIX:
            begin
                if (r0_reg != WORD_BITS'(1))
                begin
                    acc_next   = '0;
                    none_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    if (neg0_reg && (inv_mag != '0))
                    begin
                        mt_next = sub_diff[WORD_BITS-1:0];
                    end
                    else
                    begin
                        mt_next = inv_mag;
                    end
                    acc_next   = '0;
                    none_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = S_MM_DBL;
                end
            end
            S_MM_DBL, S_MM_ADD:
            begin
                acc_next = addmod_res;
                if ((state_reg == S_MM_DBL) && c_reg[WORD_BITS-1])
                begin
                    state_next = S_MM_ADD;
                end
                else
                begin
                    c_next   = c_reg << 1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MM_DBL;
                    end
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_data_next.solution = FIELD_BITS'(acc_reg);
                    rsp_data_next.no_solution = none_reg;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg        <= m_next;
        c_reg        <= c_next;
        r0_reg       <= r0_next;
        r1_reg       <= r1_next;
        t0_reg       <= t0_next;
        t1_reg       <= t1_next;
        neg0_reg     <= neg0_next;
        neg1_reg     <= neg1_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        d_reg        <= d_next;
        mq_reg       <= mq_next;
        mt_reg       <= mt_next;
        acc_reg      <= acc_next;
        none_reg     <= none_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef NO_ASSERTIONS
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.no_solution) |-> (rsp_data.solution == '0))
        else $error("no_solution response carries a nonzero solution");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RED_A || state_reg == S_RED_C || state_reg == S_EUC_DIV)
        |-> (d_reg != '0))
        else $error("divider running with a zero divisor");

    a_small_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_modulus < WORD_BITS'(2)))
        |=> (state_reg == S_DONE && none_reg))
        else $error("small modulus did not go straight to the result");

    a_bezout_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EUC_MUL) |-> (acc_reg <= m_reg))
        else $error("Bezout coefficient exceeds the modulus");
`endif

endmodule
